FILE: rtl/sce_pkg.sv
// Package for the serial frame channel extractor.
// Holds the frame constants, byte markers and channel codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sce_pkg;

  localparam int unsigned FrameLength = 25;
  localparam int unsigned PosW        = 5;
  localparam int unsigned ChanW       = 11;
  localparam int unsigned IdW         = 2;

  typedef logic [PosW-1:0]  pos_t;
  typedef logic [7:0]       byte_t;
  typedef logic [IdW-1:0]   chan_id_t;
  typedef logic [ChanW-1:0] chan_val_t;

  localparam byte_t SOF_BYTE  = 8'h0F;
  localparam byte_t IDLE_BYTE = 8'h00;

  localparam pos_t FRAME_END = pos_t'(FrameLength);
  localparam pos_t POS_CH0   = pos_t'(2);
  localparam pos_t POS_CH1   = pos_t'(3);
  localparam pos_t POS_CH2   = pos_t'(5);
  localparam pos_t POS_FIRST = pos_t'(1);
  localparam pos_t POS_LAST  = pos_t'(4);

  localparam chan_id_t CH_STEERING = 2'd0;
  localparam chan_id_t CH_THROTTLE = 2'd1;
  localparam chan_id_t CH_AUX      = 2'd2;

endpackage
`default_nettype wire

FILE: rtl/sbus_channel_extractor.sv
// Top level of the serial frame channel extractor.
// Depends on sce_pkg for constants and types.
// A result beat is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the single output register is refilled in
// the same cycle it is drained, so input stalls only while a result is held.
// Reset: asynchronous, active low; position, previous byte, stored frame
// bytes and the output valid are cleared.
`timescale 1ns / 1ps
`default_nettype none
module sbus_channel_extractor (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sce_pkg::byte_t     rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sce_pkg::chan_id_t       channel_id_o,
  output sce_pkg::chan_val_t      channel_value_o
);
  import sce_pkg::*;

  pos_t      pos_q, pos_d, pos_n;
  byte_t     prev_q;
  byte_t     fb_q [4];
  logic [1:0] wr_idx;
  logic      accept;
  logic      emit;
  chan_id_t  id_n;
  chan_val_t val_n;
  logic      out_valid_q, out_valid_d;
  chan_id_t  id_q;
  chan_val_t val_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    pos_n = pos_q;
    if (pos_q < FRAME_END) begin
      pos_n = pos_q + pos_t'(1);
    end
    if (rx_byte_i == SOF_BYTE && prev_q == IDLE_BYTE) begin
      pos_n = '0;
    end
    wr_idx = 2'(pos_n - pos_t'(1));
  end

  always_comb begin
    emit  = 1'b0;
    id_n  = CH_STEERING;
    val_n = '0;
    priority if (pos_n == POS_CH0) begin
      emit  = 1'b1;
      id_n  = CH_STEERING;
      val_n = {rx_byte_i[2:0], fb_q[0]};
    end else if (pos_n == POS_CH1) begin
      emit  = 1'b1;
      id_n  = CH_THROTTLE;
      val_n = {rx_byte_i[5:0], fb_q[1][7:3]};
    end else if (pos_n == POS_CH2) begin
      emit  = 1'b1;
      id_n  = CH_AUX;
      val_n = {rx_byte_i[0], fb_q[3], fb_q[2][7:6]};
    end
  end

  assign pos_d = accept ? pos_n : pos_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      prev_q      <= '0;
      fb_q        <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        prev_q <= rx_byte_i;
        if (pos_n >= POS_FIRST && pos_n <= POS_LAST) begin
          fb_q[wr_idx] <= rx_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      id_q  <= id_n;
      val_q <= val_n;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_id_o    = id_q;
  assign channel_value_o = val_q;

endmodule
`default_nettype wire

FILE: rtl/sce_checker.sv
// Port-level checks for the serial frame channel extractor.
// Depends on sce_pkg; bound to sbus_channel_extractor at the end of this file.
`timescale 1ns / 1ps
`default_nettype none
module sce_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire sce_pkg::byte_t     rx_byte_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire sce_pkg::chan_id_t  channel_id_o,
  input wire sce_pkg::chan_val_t channel_value_o
);
  import sce_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(channel_id_o) && $stable(channel_value_o))
    else $error("Stalled result beat changed.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the output register could take a beat.");

  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_beat))
    else $error("Result beat appeared without an input beat.");

  a_id_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (channel_id_o == CH_STEERING || channel_id_o == CH_THROTTLE ||
                     channel_id_o == CH_AUX))
    else $error("Result beat carries an unknown channel code.");

  a_sof_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && rx_byte_i == IDLE_BYTE) ##1 (in_beat && rx_byte_i == SOF_BYTE)
      |=> !out_valid_o)
    else $error("Frame start beat produced a result beat.");

endmodule

bind sbus_channel_extractor sce_checker u_sce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .rx_byte_i       (rx_byte_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .channel_id_o    (channel_id_o),
  .channel_value_o (channel_value_o)
);
`default_nettype wire

FILE: bench/testbench.sv
// Testbench for sbus_channel_extractor: a directed table, then random byte streams, most
// framed by start markers, with random idling on both sides. Needs sce_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
  import sce_pkg::*;

  typedef struct packed {
    chan_id_t  id;
    chan_val_t val;
  } chan_beat_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_kind_e;

  typedef struct packed {
    byte_t      data;
    row_kind_e  kind;
    chan_beat_t beat;
  } stim_row_t;

  localparam int unsigned TotalBytes = 1450;

  logic      clk_i           = 1'b0;
  logic      rst_ni          = 1'b0;
  logic      in_valid_i      = 1'b0;
  logic      in_stall_o;
  byte_t     rx_byte_i       = '0;
  logic      out_valid_o;
  logic      out_stall_i     = 1'b0;
  chan_id_t  channel_id_o;
  chan_val_t channel_value_o;

  pos_t        frame_pos = '0;
  byte_t       last_rx   = '0;
  byte_t       kept_bytes [1:4] = '{default: '0};
  chan_beat_t  pending_chans [$];
  chan_beat_t  head_beat;
  int unsigned mismatches     = 0;
  int unsigned bytes_sent     = 0;
  bit          quiet          = 1'b0;
  bit          long_hold_done = 1'b0;
  bit          drained_once   = 1'b0;

  // The first rows count positions from reset without any start marker.
  stim_row_t directed_rows [22] = '{
    '{8'hAA,     ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{8'hFF,     ROW_TYPED,   '{CH_STEERING, 11'h7AA}},
    '{IDLE_BYTE, ROW_TYPED,   '{CH_THROTTLE, 11'd31}},
    '{SOF_BYTE,  ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{8'hFF,     ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{8'hFF,     ROW_TYPED,   '{CH_STEERING, 11'h7FF}},
    '{8'hFF,     ROW_TYPED,   '{CH_THROTTLE, 11'h7FF}},
    '{8'hFF,     ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{8'hFF,     ROW_TYPED,   '{CH_AUX,      11'h7FF}},
    '{IDLE_BYTE, ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{SOF_BYTE,  ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{IDLE_BYTE, ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{IDLE_BYTE, ROW_TYPED,   '{CH_STEERING, 11'h000}},
    '{IDLE_BYTE, ROW_TYPED,   '{CH_THROTTLE, 11'h000}},
    '{IDLE_BYTE, ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{IDLE_BYTE, ROW_TYPED,   '{CH_AUX,      11'h000}},
    '{SOF_BYTE,  ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{IDLE_BYTE, ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{SOF_BYTE,  ROW_SILENT,  '{CH_STEERING, 11'h000}},
    '{8'h55,     ROW_PREDICT, '{CH_STEERING, 11'h000}},
    '{8'hAA,     ROW_PREDICT, '{CH_STEERING, 11'h000}},
    '{8'h3C,     ROW_PREDICT, '{CH_STEERING, 11'h000}}
  };

  sbus_channel_extractor DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit decode_byte(input byte_t b, output chan_beat_t beat);
    bit emits;
    emits = 1'b0;
    beat  = '0;
    if (frame_pos < FRAME_END) frame_pos = frame_pos + pos_t'(1);
    if (b == SOF_BYTE && last_rx == IDLE_BYTE) frame_pos = '0;
    if (frame_pos >= POS_FIRST && frame_pos <= POS_LAST) kept_bytes[frame_pos] = b;
    case (frame_pos)
      POS_CH0: begin
        beat  = '{CH_STEERING, {b[2:0], kept_bytes[1]}};
        emits = 1'b1;
      end
      POS_CH1: begin
        beat  = '{CH_THROTTLE, {b[5:0], kept_bytes[2][7:3]}};
        emits = 1'b1;
      end
      POS_CH2: begin
        beat  = '{CH_AUX, {b[0], kept_bytes[4], kept_bytes[3][7:6]}};
        emits = 1'b1;
      end
      default: ;
    endcase
    last_rx = b;
    return emits;
  endfunction

  task automatic feed(input byte_t b, input row_kind_e kind, input chan_beat_t typed);
    int unsigned gap;
    chan_beat_t  beat;
    bit          emits;
    gap = quiet ? 0 : idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    emits = decode_byte(b, beat);
    if (kind == ROW_TYPED) begin
      pending_chans.push_back(typed);
    end else if (kind == ROW_PREDICT && emits) begin
      pending_chans.push_back(beat);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chans.size() == 0) begin
        $error("Unexpected beat: channel_id %0d channel_value %0d",
               channel_id_o, channel_value_o);
        mismatches++;
      end else begin
        head_beat = pending_chans.pop_front();
        if (channel_id_o !== head_beat.id) begin
          $error("channel_id: expected %0d, actual %0d", head_beat.id, channel_id_o);
          mismatches++;
        end
        if (channel_value_o !== head_beat.val) begin
          $error("channel_value: expected %0d, actual %0d",
                 head_beat.val, channel_value_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned hold;
    forever begin
      if (!long_hold_done && bytes_sent >= 400) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (120) @(posedge clk_i);
      end
      hold = quiet ? 0 : idle_cycles();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  initial begin
    int unsigned pick;
    byte_t       b;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      feed(directed_rows[i].data, directed_rows[i].kind, directed_rows[i].beat);
    end

    while (bytes_sent < TotalBytes) begin
      quiet = (bytes_sent >= 300 && bytes_sent < 450) ||
              (bytes_sent >= 1100 && bytes_sent < 1200);
      if (!drained_once && bytes_sent >= 800) begin
        drained_once = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_chans.size() != 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        feed(IDLE_BYTE, ROW_PREDICT, '0);
        feed(SOF_BYTE, ROW_PREDICT, '0);
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 24) begin
          feed(byte_t'($urandom), ROW_PREDICT, '0);
        end
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 3))
            0:       b = IDLE_BYTE;
            1:       b = SOF_BYTE;
            default: b = byte_t'($urandom);
          endcase
          feed(b, ROW_PREDICT, '0);
        end
      end else begin
        // A long run with no start marker drives the position into saturation.
        repeat ($urandom_range(26, 40)) begin
          b = byte_t'($urandom);
          if (b == SOF_BYTE) b = ~b;
          feed(b, ROW_PREDICT, '0);
        end
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_chans.size() != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule
